// ===== src/mfgf_pkg.sv =====
package mfgf_pkg;

  // Default encoder range, counts per revolution
  localparam int unsigned EncoderCountsDef = 8192;

  // Reset values of the configuration registers
  localparam logic [10:0] YawIdRst       = 11'h207;
  localparam logic [10:0] PitchIdRst     = 11'h205;
  localparam logic [15:0] YawAngLimRst   = 16'd2000;
  localparam logic [15:0] YawSpdLimRst   = 16'd160;
  localparam logic [15:0] PitchAngLimRst = 16'd3000;
  localparam logic [15:0] PitchSpdLimRst = 16'd500;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegYawId       = 3'd0,
    RegPitchId     = 3'd1,
    RegYawAngLim   = 3'd2,
    RegYawSpdLim   = 3'd3,
    RegPitchAngLim = 3'd4,
    RegPitchSpdLim = 3'd5
  } mfgf_reg_e;

  typedef enum logic {
    ReqFrame = 1'b0,
    ReqClear = 1'b1
  } mfgf_req_e;

  typedef struct packed {
    mfgf_req_e   req_type;
    logic [10:0] can_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
  } mfgf_req_t;

  typedef struct packed {
    logic               motor_slot;
    logic [15:0]        angle_out;
    logic signed [15:0] speed_out;
    logic signed [15:0] current_out;
    logic [7:0]         temperature_out;
    logic               angle_rejected;
    logic               speed_rejected;
  } mfgf_res_t;

  // Filter state kept for one motor
  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic               seen;
  } mfgf_slot_t;

endpackage

// ===== src/mfgf_filt.sv =====
module mfgf_filt #(
  parameter int unsigned EncoderCounts = mfgf_pkg::EncoderCountsDef
) (
  input  mfgf_pkg::mfgf_req_t  req_i,
  input  logic                 slot_i,
  input  mfgf_pkg::mfgf_slot_t old_i,
  input  logic [15:0]          ang_lim_i,
  input  logic [15:0]          spd_lim_i,
  output mfgf_pkg::mfgf_slot_t new_o,
  output mfgf_pkg::mfgf_res_t  res_o
);
  import mfgf_pkg::*;

  localparam logic signed [17:0] Wrap    = 18'(EncoderCounts);
  localparam logic signed [17:0] Half    = 18'(EncoderCounts / 2);
  localparam logic signed [17:0] HalfNeg = 18'(-(EncoderCounts / 2));

  logic [15:0]        ang_new;
  logic signed [15:0] spd_new;
  logic signed [17:0] ang_d;
  logic signed [17:0] ang_w;
  logic signed [17:0] ang_abs;
  logic signed [16:0] spd_d;
  logic signed [16:0] spd_abs;
  logic               ang_rej;
  logic               spd_rej;

  // Unpack big-endian words
  assign ang_new = {req_i.byte0, req_i.byte1};
  assign spd_new = $signed({req_i.byte2, req_i.byte3});

  // Wrap-aware angle change
  always_comb begin
    ang_d = $signed({2'b00, ang_new}) - $signed({2'b00, old_i.angle});
    if (ang_d > Half) begin
      ang_w = ang_d - Wrap;
    end else if (ang_d < HalfNeg) begin
      ang_w = ang_d + Wrap;
    end else begin
      ang_w = ang_d;
    end
    ang_abs = (ang_w < 0) ? -ang_w : ang_w;
  end

  // Absolute speed change
  assign spd_d   = {spd_new[15], spd_new} - {old_i.speed[15], old_i.speed};
  assign spd_abs = (spd_d < 0) ? -spd_d : spd_d;

  // First frame after a clear accepts both values
  assign ang_rej = old_i.seen && (ang_abs > $signed({2'b00, ang_lim_i}));
  assign spd_rej = old_i.seen && (spd_abs > $signed({1'b0, spd_lim_i}));

  // Keep the stored value for a rejected field
  always_comb begin
    new_o.angle = ang_rej ? old_i.angle : ang_new;
    new_o.speed = spd_rej ? old_i.speed : spd_new;
    new_o.seen  = 1'b1;

    res_o.motor_slot      = slot_i;
    res_o.angle_out       = new_o.angle;
    res_o.speed_out       = new_o.speed;
    res_o.current_out     = $signed({req_i.byte4, req_i.byte5});
    res_o.temperature_out = req_i.byte6;
    res_o.angle_rejected  = ang_rej;
    res_o.speed_rejected  = spd_rej;
  end

endmodule

// ===== src/motor_feedback_glitch_filter_unit.sv =====
// Glitch filter for feedback frames of two motors sharing one bus.
// Input channel (in_valid_i/in_ready_o/in_req_i): a feedback frame or a
// clear request for one motor's filter state. A frame whose identifier
// matches a configured motor identifier yields one result on the output
// channel (out_valid_o/out_ready_i/out_res_o); every other request yields
// none. A clear request for an unknown identifier clears both motors.
// A request passes the input register, then its result is loaded into the
// result register. Throughput: one request per cycle unless a stalled
// receiver holds the flow, as the read-modify-write of the per-motor state
// is done between the two registers. While the receiver stalls, the result
// register holds its value and the input register keeps one more request;
// requests that give no result still drain. Configuration writes
// (cfg_we_i/cfg_idx_i/cfg_wdata_i) take effect at once; the user makes them
// only while the block is idle, as the block itself does not enforce this.
// Reset returns the configuration registers to their default values, clears
// the valid flags and the state of both motors; the first frame per motor is
// then always taken.
module motor_feedback_glitch_filter_unit #(
  parameter int unsigned EncoderCounts = mfgf_pkg::EncoderCountsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mfgf_pkg::mfgf_req_t            in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mfgf_pkg::mfgf_res_t            out_res_o,
  input  logic                           cfg_we_i,
  input  logic [mfgf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mfgf_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import mfgf_pkg::*;

  logic [10:0] yaw_id_q, pitch_id_q;
  logic [15:0] yaw_alim_q, yaw_slim_q, pitch_alim_q, pitch_slim_q;

  logic       s1_valid_q;
  mfgf_req_t  s1_q;
  logic       out_valid_q;
  mfgf_res_t  out_q;
  mfgf_slot_t slot_q [2];

  logic       hit0, hit1, hit, slot;
  logic       needs_out, out_free, s1_go;
  mfgf_slot_t slot_new;
  mfgf_res_t  res;
  logic [15:0] alim, slim;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_id_q     <= YawIdRst;
      pitch_id_q   <= PitchIdRst;
      yaw_alim_q   <= YawAngLimRst;
      yaw_slim_q   <= YawSpdLimRst;
      pitch_alim_q <= PitchAngLimRst;
      pitch_slim_q <= PitchSpdLimRst;
    end else if (cfg_we_i) begin
      unique case (mfgf_reg_e'(cfg_idx_i))
        RegYawId:       yaw_id_q     <= cfg_wdata_i[10:0];
        RegPitchId:     pitch_id_q   <= cfg_wdata_i[10:0];
        RegYawAngLim:   yaw_alim_q   <= cfg_wdata_i;
        RegYawSpdLim:   yaw_slim_q   <= cfg_wdata_i;
        RegPitchAngLim: pitch_alim_q <= cfg_wdata_i;
        RegPitchSpdLim: pitch_slim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Match identifier, first motor wins
  assign hit0 = (s1_q.can_id == yaw_id_q);
  assign hit1 = !hit0 && (s1_q.can_id == pitch_id_q);
  assign hit  = hit0 || hit1;
  assign slot = hit1;
  assign alim = slot ? pitch_alim_q : yaw_alim_q;
  assign slim = slot ? pitch_slim_q : yaw_slim_q;

  mfgf_filt #(
    .EncoderCounts(EncoderCounts)
  ) u_filt (
    .req_i    (s1_q),
    .slot_i   (slot),
    .old_i    (slot_q[slot]),
    .ang_lim_i(alim),
    .spd_lim_i(slim),
    .new_o    (slot_new),
    .res_o    (res)
  );

  // Handshake: drain requests without a result even while output stalls
  assign needs_out  = (s1_q.req_type == ReqFrame) && hit;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!needs_out || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_req_i;
    end
  end

  // Per-motor filter state: update on frames, clear on clear requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q[0] <= '0;
      slot_q[1] <= '0;
    end else if (s1_go) begin
      if (s1_q.req_type == ReqClear) begin
        if (hit) begin
          slot_q[slot] <= '0;
        end else begin
          slot_q[0] <= '0;
          slot_q[1] <= '0;
        end
      end else if (hit) begin
        slot_q[slot] <= slot_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && needs_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && needs_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // A fresh motor never rejects
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && needs_out && !slot_q[slot].seen)
      |=> (!out_q.angle_rejected && !out_q.speed_rejected))
    else $error("reject flagged on first frame after clear");

  // A rejected angle leaves the stored angle unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && needs_out && res.angle_rejected)
      |=> (slot_q[out_q.motor_slot].angle == $past(slot_q[slot].angle)))
    else $error("stored angle changed on rejection");

  // A clear for an unknown identifier clears both motors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_q.req_type == ReqClear) && !hit)
      |=> (!slot_q[0].seen && !slot_q[1].seen))
    else $error("global clear missed a motor");

  // A stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost");

  // The result side only advances with an output slot free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && needs_out) |-> out_free)
    else $error("result loaded into busy register");

endmodule
